@@ hw/rtl/cnv3_pkg.sv @@
package cnv3_pkg;

    localparam int unsigned PIX_W       = 8;
    localparam int unsigned PIX_MAX     = 255;
    localparam int unsigned MAX_WIDTH   = 2048;
    localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W       = 16;
    localparam int unsigned WIDTH_REG_W = 12;
    localparam int unsigned COEF_W      = 16;
    localparam int unsigned COEF_ROW_W  = 3 * COEF_W;
    localparam int unsigned FRAC_W      = 12;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = COEF_ROW_W;
    localparam int unsigned N_TAP       = 9;
    localparam int unsigned N_RES       = 4;
    localparam int unsigned PROD_W      = PIX_W + 1 + COEF_W;
    localparam int unsigned SUM_W       = PROD_W + 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_COEF_TOP     = 3'd2,
        CFG_COEF_MIDDLE  = 3'd3,
        CFG_COEF_BOTTOM  = 3'd4
    } t_cfg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic                   valid;
        logic [N_TAP-1:0][PIX_W-1:0] tap;
        logic                   last;
        logic                   done;
    } t_conv_req;

endpackage

@@ hw/rtl/cnv3_line_store.sv @@
module cnv3_line_store (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [cnv3_pkg::COL_W-1:0] i_rd_addr,
    output cnv3_pkg::t_pix            o_older,
    output cnv3_pkg::t_pix            o_newer,
    input  logic                      i_wr_en,
    input  logic [cnv3_pkg::COL_W-1:0] i_wr_addr,
    input  cnv3_pkg::t_pix            i_wr_older,
    input  cnv3_pkg::t_pix            i_wr_newer
);
    import cnv3_pkg::*;

    t_pix r_mem_older [MAX_WIDTH];
    t_pix r_mem_newer [MAX_WIDTH];
    t_pix r_older;
    t_pix r_newer;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_older[i_wr_addr] <= i_wr_older;
            r_mem_newer[i_wr_addr] <= i_wr_newer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_older <= r_mem_older[i_rd_addr];
            r_newer <= r_mem_newer[i_rd_addr];
        end
    end

    assign o_older = r_older;
    assign o_newer = r_newer;

endmodule

@@ hw/rtl/cnv3_conv.sv @@
module cnv3_conv (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic [2:0][cnv3_pkg::COEF_ROW_W-1:0]      i_coef,
    input  cnv3_pkg::t_conv_req                       i_req,
    output logic                                      o_ready,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output cnv3_pkg::t_pix                            o_pixel,
    output logic                                      o_last,
    output logic                                      o_done
);
    import cnv3_pkg::*;

    logic                     r_p_valid;
    logic signed [PROD_W-1:0] r_prod [N_TAP];
    logic signed [PROD_W-1:0] n_prod [N_TAP];
    logic                     r_p_last;
    logic                     r_p_done;

    logic                     r_o_valid;
    t_pix                     r_o_pixel;
    logic                     r_o_last;
    logic                     r_o_done;

    logic                     o_free;
    logic                     p_free;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-FRAC_W-1:0]  whole;
    t_pix                     n_pixel;

    assign o_free  = !r_o_valid || !i_stall;
    assign p_free  = !r_p_valid || o_free;
    assign o_ready = p_free;

    // true convolution: tap (k,m) meets coefficient (2-k,2-m)
    always_comb begin
        logic signed [COEF_W-1:0] cf;
        for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
                cf = i_coef[2-k][COEF_W*(2-m) +: COEF_W];
                n_prod[3*k+m] = $signed({1'b0, i_req.tap[3*k+m]}) * cf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (p_free) begin
            r_p_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_free && i_req.valid) begin
            r_prod   <= n_prod;
            r_p_last <= i_req.last;
            r_p_done <= i_req.done;
        end
    end

    always_comb begin
        sum = ((SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]))
             + (SUM_W'(r_prod[2]) + SUM_W'(r_prod[3])))
            + ((SUM_W'(r_prod[4]) + SUM_W'(r_prod[5]))
             + (SUM_W'(r_prod[6]) + SUM_W'(r_prod[7])))
            + SUM_W'(r_prod[8]);
        whole = sum[SUM_W-1:FRAC_W];
        if (sum[SUM_W-1]) begin
            n_pixel = '0;
        end else if (whole > (SUM_W-FRAC_W)'(PIX_MAX)) begin
            n_pixel = PIX_W'(PIX_MAX);
        end else begin
            n_pixel = whole[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_free) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && r_p_valid) begin
            r_o_pixel <= n_pixel;
            r_o_last  <= r_p_last;
            r_o_done  <= r_p_done;
        end
    end

    assign o_valid = r_o_valid;
    assign o_pixel = r_o_pixel;
    assign o_last  = r_o_last;
    assign o_done  = r_o_done;

endmodule

@@ hw/rtl/conv3x3_replicate_border_clamp.sv @@
// 3x3 convolution with replicated borders and 0..255 clamping.
//
// Input channel: i_in_valid / o_in_stall carry one 8-bit pixel per transfer,
// raster order, rows of image_width pixels, frames of image_height rows.
// Output channel: o_out_valid / i_out_stall carry one filtered pixel per
// transfer, raster order, lagging input by one row and one column.
// o_last_of_run marks the final result released by an input pixel and
// o_frame_done marks the bottom-right result of a frame.
// Config: i_cfg_we writes i_cfg_data into the register picked by
// i_cfg_index (width, height, three kernel rows of signed Q4.12); write only
// while the block is idle.
// Throughput: one pixel per clock while the output does not stall; a pixel
// that releases n results holds the input until all n are issued, since a
// single 9-tap multiply stage serves one result per clock when not stalled
// (row ends and the last row release up to four).
// Reset clears counters, window and pipeline; registers return to width
// 2048, height 1, identity kernel. Line stores are not cleared.
// A stall on the output backs up through the pipeline into o_in_stall.
module conv3x3_replicate_border_clamp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cnv3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cnv3_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [cnv3_pkg::PIX_W-1:0]         i_pixel_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [cnv3_pkg::PIX_W-1:0]         o_pixel_out,
    output logic                               o_last_of_run,
    output logic                               o_frame_done
);
    import cnv3_pkg::*;

    localparam logic [1:0] RES_PREV_MID = 2'd0;
    localparam logic [1:0] RES_PREV_END = 2'd1;
    localparam logic [1:0] RES_LAST_MID = 2'd2;
    localparam logic [1:0] RES_LAST_END = 2'd3;

    logic [WIDTH_REG_W-1:0]      r_image_width;
    logic [ROW_W-1:0]            r_image_height;
    logic [2:0][COEF_ROW_W-1:0]  r_coef;

    logic [COL_W-1:0]            r_col;
    logic [ROW_W-1:0]            r_row;

    logic                        r_a_valid;
    t_pix                        r_a_pix;
    logic [COL_W-1:0]            r_a_col;
    logic                        r_a_c0;
    logic                        r_a_r1;
    logic                        r_a_r2;
    logic [N_RES-1:0]            r_a_mask;
    logic                        r_fwd;
    t_pix                        r_fwd_old;
    t_pix                        r_fwd_new;

    logic [2:0][2:0][PIX_W-1:0]  r_win;
    logic [2:0][2:0][PIX_W-1:0]  n_win;
    logic                        r_job_valid;
    logic [N_RES-1:0]            r_job_mask;
    logic [2:0][2:0][PIX_W-1:0]  r_job_win;

    logic                        in_accept;
    logic                        a_adv;
    logic                        job_fire;
    logic                        job_free;
    logic                        conv_ready;
    logic [WIDTH_REG_W-1:0]      w_m1;
    logic [ROW_W-1:0]            h_m1;
    logic                        row_end;
    logic                        last_row;
    logic                        c_ge1;
    logic                        r_ge1;
    logic [N_RES-1:0]            n_mask;
    logic                        hazard;
    t_pix                        rd_old;
    t_pix                        rd_new;
    t_pix                        a_old;
    t_pix                        a_new;
    t_pix [2:0]                  col_v;
    logic [1:0]                  sel;
    logic [N_RES-1:0]            job_rest;
    t_conv_req                   req;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_REG_W'(MAX_WIDTH);
            r_image_height <= ROW_W'(1);
            r_coef[0]      <= '0;
            r_coef[1]      <= COEF_ROW_W'(1 << (COEF_W + FRAC_W));
            r_coef[2]      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[ROW_W-1:0];
                CFG_COEF_TOP:     r_coef[0]      <= i_cfg_data[COEF_ROW_W-1:0];
                CFG_COEF_MIDDLE:  r_coef[1]      <= i_cfg_data[COEF_ROW_W-1:0];
                CFG_COEF_BOTTOM:  r_coef[2]      <= i_cfg_data[COEF_ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // frame position
    always_comb begin
        if (r_image_width == '0) begin
            w_m1 = '0;
        end else if (r_image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
            w_m1 = WIDTH_REG_W'(MAX_WIDTH - 1);
        end else begin
            w_m1 = r_image_width - 1'b1;
        end
        h_m1     = (r_image_height == '0) ? '0 : r_image_height - 1'b1;
        row_end  = WIDTH_REG_W'(r_col) >= w_m1;
        last_row = r_row >= h_m1;
        c_ge1    = r_col != '0;
        r_ge1    = r_row != '0;
        n_mask[RES_PREV_MID] = c_ge1 && r_ge1;
        n_mask[RES_PREV_END] = row_end && r_ge1;
        n_mask[RES_LAST_MID] = c_ge1 && last_row;
        n_mask[RES_LAST_END] = row_end && last_row;
    end

    assign job_free   = !r_job_valid || (job_fire && job_rest == '0);
    assign a_adv      = r_a_valid && ((r_a_mask == '0) || job_free);
    assign o_in_stall = r_a_valid && !a_adv;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign hazard     = a_adv && (r_a_col == r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_pix   <= i_pixel_in;
            r_a_col   <= r_col;
            r_a_c0    <= !c_ge1;
            r_a_r1    <= r_ge1;
            r_a_r2    <= r_row > ROW_W'(1);
            r_a_mask  <= n_mask;
            r_fwd     <= hazard;
            r_fwd_old <= a_new;
            r_fwd_new <= r_a_pix;
        end
    end

    cnv3_line_store u_line_store (
        .i_clk      (i_clk),
        .i_rd_en    (in_accept),
        .i_rd_addr  (r_col),
        .o_older    (rd_old),
        .o_newer    (rd_new),
        .i_wr_en    (a_adv),
        .i_wr_addr  (r_a_col),
        .i_wr_older (a_new),
        .i_wr_newer (r_a_pix)
    );

    // same column written by the item ahead in the same cycle
    assign a_old = r_fwd ? r_fwd_old : rd_old;
    assign a_new = r_fwd ? r_fwd_new : rd_new;

    // window
    always_comb begin
        col_v[2] = r_a_pix;
        col_v[1] = r_a_r1 ? a_new : r_a_pix;
        col_v[0] = r_a_r2 ? a_old : col_v[1];
        for (int i = 0; i < 3; i++) begin
            if (r_a_c0) begin
                n_win[i][0] = col_v[i];
                n_win[i][1] = col_v[i];
            end else begin
                n_win[i][0] = r_win[i][1];
                n_win[i][1] = r_win[i][2];
            end
            n_win[i][2] = col_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (a_adv) begin
            r_win <= n_win;
        end
    end

    // result sequencer
    always_comb begin
        if (r_job_mask[RES_PREV_MID]) begin
            sel = RES_PREV_MID;
        end else if (r_job_mask[RES_PREV_END]) begin
            sel = RES_PREV_END;
        end else if (r_job_mask[RES_LAST_MID]) begin
            sel = RES_LAST_MID;
        end else begin
            sel = RES_LAST_END;
        end
        job_rest      = r_job_mask;
        job_rest[sel] = 1'b0;
    end

    assign job_fire = r_job_valid && conv_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_job_mask  <= '0;
        end else if (a_adv && r_a_mask != '0) begin
            r_job_valid <= 1'b1;
            r_job_mask  <= r_a_mask;
        end else if (job_fire) begin
            r_job_valid <= job_rest != '0;
            r_job_mask  <= job_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && r_a_mask != '0) begin
            r_job_win <= n_win;
        end
    end

    // rows {1,2,2} for the last row, columns {1,2,2} at row end
    always_comb begin
        int  rk;
        int  cm;
        logic use_last;
        logic use_end;
        use_last  = sel == RES_LAST_MID || sel == RES_LAST_END;
        use_end   = sel == RES_PREV_END || sel == RES_LAST_END;
        req.valid = r_job_valid;
        req.last  = job_rest == '0;
        req.done  = sel == RES_LAST_END;
        for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
                rk = use_last ? ((k == 0) ? 1 : 2) : k;
                cm = use_end ? ((m == 0) ? 1 : 2) : m;
                req.tap[3*k+m] = r_job_win[rk][cm];
            end
        end
    end

    cnv3_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (r_coef),
        .i_req   (req),
        .o_ready (conv_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_pixel (o_pixel_out),
        .o_last  (o_last_of_run),
        .o_done  (o_frame_done)
    );

    a_job_mask_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> r_job_mask != '0)
        else $error("pending results with empty mask");

    a_job_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_adv && r_a_mask != '0) |-> job_free)
        else $error("result job overwritten");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> o_last_of_run)
        else $error("frame end not last of run");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && row_end && last_row) |=> (r_col == '0 && r_row == '0))
        else $error("counters did not wrap at frame end");

endmodule
